/* rtl/lpbd_pkg.sv */
package lpbd_pkg;

   localparam int DB_W     = 16;
   localparam int LVL_W    = 16;
   localparam int POS_W    = 48;
   localparam int THR_W    = 16;
   localparam int LEN_W    = 9;
   localparam int HOLD_W   = 16;
   localparam int CSR_W    = 16;
   localparam int DB_SCALE = 771;

   localparam int QDEPTH = 8;
   localparam int QCW    = $clog2(QDEPTH + 1);
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(2560);
   localparam logic [LEN_W-1:0]  WINDOW_RST    = LEN_W'(16);
   localparam logic [LEN_W-1:0]  GUARD_RST     = LEN_W'(0);
   localparam logic [HOLD_W-1:0] HOLDOFF_RST   = HOLD_W'(0);

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_GUARD     = 2'd2,
      CSR_HOLDOFF   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [LEN_W-1:0]  window;
      logic [LEN_W-1:0]  guard;
      logic [HOLD_W-1:0] holdoff;
   } cfg_type;

endpackage

/* rtl/log_power_burst_detector_unit.sv */
// Log-power burst detector. Each req beat carries one complex sample; each rsp beat
// carries the windowed dB level change and burst start/end flags with the tagged
// sample number. A 6-stage front pipeline (squares, sum, leading-one, mantissa,
// dB scale) feeds an 8-entry queue, so req beats are taken every cycle while the
// queue has room. The back end handles one beat at a time: while the delay line is
// still filling it skips the divide, and once level_valid is set it runs a
// bit-serial divide of the window sum difference by window_length, with SUM_W =
// 16 + clog2(MAX_WINDOW + 1). A write to window_length or guard_length starts a
// rebuild of both window sums from the delay line before the next beat is
// processed.
module log_power_burst_detector_unit import lpbd_pkg::*; #(
   parameter int MAX_WINDOW  = 256,
   parameter int MAX_GUARD   = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_q,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [LVL_W-1:0]       rsp_level_change,
   output logic                          rsp_level_valid,
   output logic                          rsp_burst_start,
   output logic                          rsp_burst_end,
   output logic [POS_W-1:0]              rsp_event_position,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic recalc;
   logic push, pop, q_nonempty;
   logic [DB_W-1:0] push_db, pop_db;
   logic [QCW-1:0] q_count;

   always_comb begin
      cfg_in = cfg_ff;
      recalc = 1'b0;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: cfg_in.threshold = THR_W'(csr_wdata);
            CSR_WINDOW: begin
               cfg_in.window = LEN_W'(csr_wdata);
               recalc        = 1'b1;
            end
            CSR_GUARD: begin
               cfg_in.guard = LEN_W'(csr_wdata);
               recalc       = 1'b1;
            end
            CSR_HOLDOFF: cfg_in.holdoff = HOLD_W'(csr_wdata);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.window    <= WINDOW_RST;
         cfg_ff.guard     <= GUARD_RST;
         cfg_ff.holdoff   <= HOLDOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpbd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample_i(req_sample_i),
      .req_sample_q(req_sample_q),
      .q_count     (q_count),
      .push        (push),
      .push_db     (push_db)
   );

   lpbd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_db (push_db),
      .pop     (pop),
      .pop_db  (pop_db),
      .nonempty(q_nonempty),
      .count   (q_count)
   );

   lpbd_back #(
      .MAX_WINDOW(MAX_WINDOW),
      .MAX_GUARD (MAX_GUARD)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .recalc            (recalc),
      .q_nonempty        (q_nonempty),
      .q_db              (pop_db),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_change  (rsp_level_change),
      .rsp_level_valid   (rsp_level_valid),
      .rsp_burst_start   (rsp_burst_start),
      .rsp_burst_end     (rsp_burst_end),
      .rsp_event_position(rsp_event_position)
   );

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_burst_start && rsp_burst_end))
      else $error("start and end in one beat");

   a_event_needs_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_burst_start || rsp_burst_end) |-> rsp_level_valid)
      else $error("event raised before delay line full");

   a_quiet_when_filling: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_burst_start && !rsp_burst_end |-> rsp_event_position == '0)
      else $error("position without event");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(q_count) <= QDEPTH)
      else $error("queue overrun");

endmodule

/* rtl/lpbd_front.sv */
module lpbd_front import lpbd_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_q,
   input  logic [QCW-1:0]                q_count,
   output logic                          push,
   output logic [DB_W-1:0]               push_db
);

   localparam int PW   = 2 * SAMPLE_BITS;
   localparam int EW   = $clog2(PW);
   localparam int LGW  = EW + 8;
   localparam int MW   = LGW + 10;
   localparam int NST  = 6;
   localparam int CRW  = QCW + 1;

   logic [NST-1:0] vld_ff, vld_in;
   logic signed [SAMPLE_BITS-1:0] i_ff, q_ff;
   logic [PW-1:0] ii_ff, qq_ff, p3_ff, p4_ff, psum;
   logic [EW-1:0] e_ff, e_in;
   logic [LGW-1:0] lg_ff;
   logic [PW+7:0] shifted;
   logic [DB_W-1:0] db_ff;
   logic [MW-1:0] prod;
   logic accept;

   // credit: every beat in flight already owns a queue slot
   assign req_ready = (CRW'(q_count) + CRW'($countones(vld_ff))) < CRW'(QDEPTH);
   assign accept = req_valid & req_ready;
   assign vld_in = {vld_ff[NST-2:0], accept};

   assign psum = ii_ff + qq_ff;

   always_comb begin
      e_in = '0;
      for (int k = 0; k < PW; k++) begin
         if (p3_ff[k]) begin
            e_in = EW'(k);
         end
      end
   end

   assign shifted = ({8'd0, p4_ff} << 8) >> e_ff;
   assign prod = MW'(lg_ff) * MW'(DB_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         i_ff <= req_sample_i;
         q_ff <= req_sample_q;
      end
      ii_ff <= PW'(i_ff * i_ff);
      qq_ff <= PW'(q_ff * q_ff);
      p3_ff <= (psum == '0) ? PW'(1) : psum;
      p4_ff <= p3_ff;
      e_ff  <= e_in;
      lg_ff <= {e_ff, shifted[7:0]};
      db_ff <= DB_W'(prod >> 8);
   end

   assign push    = vld_ff[NST-1];
   assign push_db = db_ff;

endmodule

/* rtl/lpbd_queue.sv */
module lpbd_queue import lpbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  logic [DB_W-1:0] push_db,
   input  logic            pop,
   output logic [DB_W-1:0] pop_db,
   output logic            nonempty,
   output logic [QCW-1:0]  count
);

   logic [DB_W-1:0] slot_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         count_ff <= count_ff + QCW'(push) - QCW'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_db;
      end
   end

   assign pop_db   = slot_ff[rd_ptr_ff];
   assign nonempty = (count_ff != '0);
   assign count    = count_ff;

endmodule

/* rtl/lpbd_back.sv */
module lpbd_back import lpbd_pkg::*; #(
   parameter int MAX_WINDOW = 256,
   parameter int MAX_GUARD  = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    recalc,
   input  logic                    q_nonempty,
   input  logic [DB_W-1:0]         q_db,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [LVL_W-1:0] rsp_level_change,
   output logic                    rsp_level_valid,
   output logic                    rsp_burst_start,
   output logic                    rsp_burst_end,
   output logic [POS_W-1:0]        rsp_event_position
);

   localparam int DEPTH = MAX_WINDOW + MAX_GUARD + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(MAX_WINDOW + 1);
   localparam int GW    = $clog2(MAX_GUARD + 2);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int SUM_W = DB_W + NW;
   localparam int CW    = $clog2(SUM_W);
   localparam int TW    = AW + 2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SWEEP = 6'b000010,
      ST_UPD   = 6'b000100,
      ST_PREP  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [DB_W-1:0] mem_a [DEPTH];
   logic [DB_W-1:0] mem_b [DEPTH];
   logic [DB_W-1:0] mem_c [DEPTH];
   logic [DB_W-1:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic [AW-1:0] addr_a, addr_b, addr_c, head_next;
   logic mem_we;

   logic [NW-1:0] n;
   logic [GW-1:0] g;
   logic [AW-1:0] xa_item, xb_item, xc_item, xa_swp, xb_swp;

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in, fill_new;
   logic [SUM_W-1:0] recent_ff, recent_in, delayed_ff, delayed_in;
   logic [DB_W-1:0] db_ff, db_in;
   logic recalc_ff, recalc_in;
   logic [NW-1:0] k_ff, k_in;
   logic swp_vld_ff, swp_vld_in, swp_ma_ff, swp_ma_in, swp_mb_ff, swp_mb_in;
   logic valid_ff, valid_in;
   logic [TW-1:0] tap_ff, tap_in, tap3_ff, tap3_in;
   logic neg_ff, neg_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_start_ff, pos_start_in, pos_end_ff, pos_end_in;
   logic [POS_W-1:0] sc_ff, sc_in;
   logic in_burst_ff, in_burst_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [LVL_W-1:0] lvl_ff, lvl_in;
   logic lvld_ff, lvld_in, start_ff, start_in, end_ff, end_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic ma, mb, mc;
   logic [SUM_W:0] diff, rem_sh;
   logic signed [SUM_W:0] chg_w;
   logic signed [LVL_W-1:0] chg;
   logic signed [LVL_W+1:0] chg_x, thr_x;

   function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] h,
                                                input logic [AW-1:0] x);
      logic [AW:0] d;
      d = {1'b0, h} - {1'b0, x};
      if (d[AW]) begin
         d = d + (AW+1)'(DEPTH);
      end
      return d[AW-1:0];
   endfunction

   always_comb begin
      if (cfg.window == '0) begin
         n = NW'(1);
      end else if (32'(cfg.window) > MAX_WINDOW) begin
         n = NW'(MAX_WINDOW);
      end else begin
         n = NW'(cfg.window);
      end
      if (32'(cfg.guard) > MAX_GUARD) begin
         g = GW'(MAX_GUARD);
      end else begin
         g = GW'(cfg.guard);
      end
   end

   // distances back from the head, before this beat's write
   assign xa_item = AW'(n) - AW'(1);
   assign xb_item = AW'(g);
   assign xc_item = AW'(n) + AW'(g);
   assign xa_swp  = AW'(k_ff);
   assign xb_swp  = AW'(k_ff) + AW'(g) + AW'(1);

   assign addr_a = (state_ff == ST_SWEEP) ? back_addr(head_ff, xa_swp)
                                          : back_addr(head_ff, xa_item);
   assign addr_b = (state_ff == ST_SWEEP) ? back_addr(head_ff, xb_swp)
                                          : back_addr(head_ff, xb_item);
   assign addr_c = back_addr(head_ff, xc_item);
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign mem_we = (state_ff == ST_UPD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_a[head_next] <= db_ff;
         mem_b[head_next] <= db_ff;
         mem_c[head_next] <= db_ff;
      end
      rd_a_ff <= mem_a[addr_a];
      rd_b_ff <= mem_b[addr_b];
      rd_c_ff <= mem_c[addr_c];
   end

   // entries never written read as zero
   assign ma = FW'(xa_item) < fill_ff;
   assign mb = FW'(xb_item) < fill_ff;
   assign mc = FW'(xc_item) < fill_ff;
   assign fill_new = (fill_ff == FW'(DEPTH)) ? fill_ff : fill_ff + FW'(1);

   assign diff   = {1'b0, recent_ff} - {1'b0, delayed_ff};
   assign rem_sh = (SUM_W+1)'({rem_ff, quo_ff[SUM_W-1]});

   always_comb begin
      chg_w = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (!valid_ff) begin
         chg = '0;
      end else if (chg_w > $signed((SUM_W+1)'(32767))) begin
         chg = LVL_W'(32767);
      end else if (chg_w < -$signed((SUM_W+1)'(32768))) begin
         chg = LVL_W'(-32768);
      end else begin
         chg = LVL_W'(chg_w);
      end
   end

   assign chg_x = (LVL_W+2)'(chg);
   assign thr_x = $signed({2'b00, cfg.threshold});

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      recent_in    = recent_ff;
      delayed_in   = delayed_ff;
      db_in        = db_ff;
      recalc_in    = recalc | recalc_ff;
      k_in         = k_ff;
      swp_vld_in   = 1'b0;
      swp_ma_in    = FW'(xa_swp) < fill_ff;
      swp_mb_in    = FW'(xb_swp) < fill_ff;
      valid_in     = valid_ff;
      tap_in       = tap_ff;
      tap3_in      = tap3_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pos_start_in = pos_start_ff;
      pos_end_in   = pos_end_ff;
      sc_in        = sc_ff;
      in_burst_in  = in_burst_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      lvl_in       = lvl_ff;
      lvld_in      = lvld_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      pos_in       = pos_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (recalc_ff) begin
               recent_in  = '0;
               delayed_in = '0;
               k_in       = '0;
               state_in   = ST_SWEEP;
            end else if (q_nonempty && (!rsp_valid_ff || rsp_ready)) begin
               // the output register is empty or drains this cycle, before FIN writes it
               q_pop    = 1'b1;
               db_in    = q_db;
               state_in = ST_UPD;
            end
         end
         ST_SWEEP: begin
            // reads arrive in the cycle after the index that addressed them
            if (swp_vld_ff) begin
               recent_in  = recent_ff + (swp_ma_ff ? SUM_W'(rd_a_ff) : '0);
               delayed_in = delayed_ff + (swp_mb_ff ? SUM_W'(rd_b_ff) : '0);
            end
            swp_vld_in = (k_ff < n);
            k_in       = k_ff + NW'(1);
            if (k_ff == n) begin
               recalc_in = recalc;
               state_in  = ST_IDLE;
            end
         end
         ST_UPD: begin
            recent_in  = recent_ff + SUM_W'(db_ff) - (ma ? SUM_W'(rd_a_ff) : '0);
            delayed_in = delayed_ff + (mb ? SUM_W'(rd_b_ff) : '0)
                                    - (mc ? SUM_W'(rd_c_ff) : '0);
            head_in  = head_next;
            fill_in  = fill_new;
            valid_in = (32'(fill_new) >= 32'(n) + 32'(g) + 1);
            tap_in   = TW'((AW'(n) + AW'(g)) >> 1);
            tap3_in  = TW'((AW'(n) + AW'(g)) >> 1) * TW'(3);
            state_in = valid_in ? ST_PREP : ST_FIN;
         end
         ST_PREP: begin
            neg_in       = diff[SUM_W];
            quo_in       = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
            rem_in       = '0;
            cnt_in       = '0;
            pos_start_in = sc_ff + POS_W'(tap_ff);
            pos_end_in   = sc_ff + POS_W'(tap3_ff) + POS_W'(cfg.holdoff);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= (SUM_W+1)'(n)) begin
               rem_in = NW'(rem_sh - (SUM_W+1)'(n));
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = NW'(rem_sh);
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SUM_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            lvl_in       = chg;
            lvld_in      = valid_ff;
            start_in     = 1'b0;
            end_in       = 1'b0;
            pos_in       = '0;
            if (valid_ff) begin
               if (!in_burst_ff) begin
                  if (chg_x > thr_x) begin
                     start_in    = 1'b1;
                     in_burst_in = 1'b1;
                     pos_in      = pos_start_ff;
                  end
               end else if (chg_x < -thr_x) begin
                  end_in      = 1'b1;
                  in_burst_in = 1'b0;
                  pos_in      = pos_end_ff;
               end
            end
            sc_in    = sc_ff + POS_W'(1);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         recent_ff    <= '0;
         delayed_ff   <= '0;
         recalc_ff    <= 1'b0;
         swp_vld_ff   <= 1'b0;
         sc_ff        <= '0;
         in_burst_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         recent_ff    <= recent_in;
         delayed_ff   <= delayed_in;
         recalc_ff    <= recalc_in;
         swp_vld_ff   <= swp_vld_in;
         sc_ff        <= sc_in;
         in_burst_ff  <= in_burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      db_ff        <= db_in;
      k_ff         <= k_in;
      swp_ma_ff    <= swp_ma_in;
      swp_mb_ff    <= swp_mb_in;
      valid_ff     <= valid_in;
      tap_ff       <= tap_in;
      tap3_ff      <= tap3_in;
      neg_ff       <= neg_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      pos_start_ff <= pos_start_in;
      pos_end_ff   <= pos_end_in;
      lvl_ff       <= lvl_in;
      lvld_ff      <= lvld_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      pos_ff       <= pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_change   = lvl_ff;
   assign rsp_level_valid    = lvld_ff;
   assign rsp_burst_start    = start_ff;
   assign rsp_burst_end      = end_ff;
   assign rsp_event_position = pos_ff;

endmodule
